/* sv/sslt_pkg.sv */
// ----------------------------------------------------------------------------
// sslt_pkg
// shared types and constants for the source sequence loss tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sslt_pkg;

   localparam int NODES_DEFAULT = 16;

   localparam int ADDR_HALF_W = 64;
   localparam int ADDR_W      = 2 * ADDR_HALF_W;
   localparam int SEQ_W       = 32;
   localparam int PARENT_W    = 64;
   localparam int GAP_W       = 16;
   localparam int CHANGE_W    = 8;
   localparam int STATUS_W    = 2;
   localparam int SLOT_W      = 4;
   localparam int USED_W      = 5;

   localparam logic [GAP_W-1:0]    GAP_MAX    = 16'hFFFF;
   localparam logic [CHANGE_W-1:0] CHANGE_MAX = 8'hFF;

   localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]    last_seq;
      logic [GAP_W-1:0]    gap_count;
      logic [CHANGE_W-1:0] change_count;
      logic [PARENT_W-1:0] parent;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

`default_nettype wire

/* sv/sslt_ram.sv */
// ----------------------------------------------------------------------------
// sslt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sslt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/sslt_ctrl.sv */
// ----------------------------------------------------------------------------
// sslt_ctrl
// sequencer: pipelined address scan, record read-modify-write, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sslt_ctrl
   import sslt_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT,
   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1,
   localparam int CNT_W = $clog2(NODES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [ADDR_HALF_W-1:0] req_source_addr_high,
   input  wire logic [ADDR_HALF_W-1:0] req_source_addr_low,
   input  wire logic [SEQ_W-1:0]       req_msg_number,
   input  wire logic [PARENT_W-1:0]    req_parent_id,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [SLOT_W-1:0]           rsp_slot,
   output logic                        rsp_parent_switched,
   output logic [GAP_W-1:0]            rsp_gap_events,
   output logic [CHANGE_W-1:0]         rsp_parent_change_total,
   output logic [USED_W-1:0]           rsp_entries_used,
   output logic                        mem_rd_en,
   output logic [IDX_W-1:0]            mem_rd_addr,
   output logic                        addr_wr_en,
   output logic                        rec_wr_en,
   output logic [IDX_W-1:0]            mem_wr_addr,
   output logic [ADDR_W-1:0]           addr_wr_data,
   output rec_type                     rec_wr_data,
   input  wire logic [ADDR_W-1:0]      addr_rd_data,
   input  wire rec_type                rec_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPD,
      S_MISS
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [SEQ_W-1:0]        num_ff, num_in;
   logic [PARENT_W-1:0]     par_ff, par_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   rec_type                 rec_ff, rec_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [SLOT_W-1:0]       rslot_ff, rslot_in;
   logic                    switched_ff, switched_in;
   logic [GAP_W-1:0]        gaps_ff, gaps_in;
   logic [CHANGE_W-1:0]     changes_ff, changes_in;
   logic [USED_W-1:0]       used_ff, used_in;

   logic                    out_free;
   logic                    match;
   logic [SEQ_W-1:0]        seq_next;
   logic                    gap_hit;
   logic                    par_diff;
   rec_type                 rec_upd;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign match    = cmp_vld_ff && (addr_rd_data == addr_ff);

   // record update for a known source
   always_comb begin
      seq_next = rec_ff.last_seq + SEQ_W'(1);
      gap_hit  = (seq_next != num_ff);
      par_diff = (rec_ff.parent != par_ff);
      rec_upd  = rec_ff;
      rec_upd.last_seq = num_ff;
      if (gap_hit && (rec_ff.gap_count != GAP_MAX)) begin
         rec_upd.gap_count = rec_ff.gap_count + GAP_W'(1);
      end
      if (par_diff) begin
         rec_upd.parent = par_ff;
         if (rec_ff.change_count != CHANGE_MAX) begin
            rec_upd.change_count = rec_ff.change_count + CHANGE_W'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      num_in       = num_ff;
      par_in       = par_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      slot_in      = slot_ff;
      rec_in       = rec_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rslot_in     = rslot_ff;
      switched_in  = switched_ff;
      gaps_in      = gaps_ff;
      changes_in   = changes_ff;
      used_in      = used_ff;

      mem_rd_en    = 1'b0;
      mem_rd_addr  = issue_ff[IDX_W-1:0];
      addr_wr_en   = 1'b0;
      rec_wr_en    = 1'b0;
      mem_wr_addr  = (state_ff == S_UPD) ? slot_ff : count_ff[IDX_W-1:0];
      addr_wr_data = addr_ff;
      rec_wr_data  = rec_upd;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               addr_in    = {req_source_addr_high, req_source_addr_low};
               num_in     = req_msg_number;
               par_in     = req_parent_id;
               issue_in   = '0;
               cmp_vld_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (match) begin
               slot_in    = cmp_idx_ff;
               rec_in     = rec_rd_data;
               cmp_vld_in = 1'b0;
               state_in   = S_UPD;
            end else if (issue_ff < count_ff) begin
               mem_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in   = S_MISS;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         S_UPD: begin
            if (out_free) begin
               rec_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = STATUS_UPDATED;
               rslot_in     = SLOT_W'(slot_ff);
               switched_in  = par_diff;
               gaps_in      = rec_upd.gap_count;
               changes_in   = rec_upd.change_count;
               used_in      = USED_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         S_MISS: begin
            rec_wr_data.last_seq     = num_ff;
            rec_wr_data.gap_count    = '0;
            rec_wr_data.change_count = '0;
            rec_wr_data.parent       = par_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               switched_in  = 1'b0;
               gaps_in      = '0;
               changes_in   = '0;
               state_in     = S_IDLE;
               if (count_ff < CNT_W'(NODES)) begin
                  addr_wr_en = 1'b1;
                  rec_wr_en  = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
                  status_in  = STATUS_NEW;
                  rslot_in   = SLOT_W'(count_ff[IDX_W-1:0]);
                  used_in    = USED_W'(count_ff + CNT_W'(1));
               end else begin
                  status_in  = STATUS_REJECTED;
                  rslot_in   = '0;
                  used_in    = USED_W'(count_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      num_ff      <= num_in;
      par_ff      <= par_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
      rec_ff      <= rec_in;
      status_ff   <= status_in;
      rslot_ff    <= rslot_in;
      switched_ff <= switched_in;
      gaps_ff     <= gaps_in;
      changes_ff  <= changes_in;
      used_ff     <= used_in;
   end

   assign req_ready               = (state_ff == S_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_slot                = rslot_ff;
   assign rsp_parent_switched     = switched_ff;
   assign rsp_gap_events          = gaps_ff;
   assign rsp_parent_change_total = changes_ff;
   assign rsp_entries_used        = used_ff;

endmodule

`default_nettype wire

/* sv/source_sequence_loss_tracker_top.sv */
// ----------------------------------------------------------------------------
// source_sequence_loss_tracker_top
// per-source sequence gap and parent change tracking over a table of sources
//
// channel  direction  handshake             payload
// req_     in         req_valid/req_ready   source address halves, msg number, parent
// rsp_     out        rsp_valid/rsp_ready   status, slot, switch flag, counters, used
//
// a request is taken from idle, then the scan reads the stored addresses in turn, each
// read overlapping the compare of the one before it, and stops at a hit; a miss adds a
// closing scan step; a last step writes the record (not for a rejected miss) and loads
// the result, and the sequencer returns to idle
// one request in flight; the next is taken while the result register still waits
// synchronous reset empties the table at once via the fill count, no clearing pass
// a stalled result holds the sequencer in its final step until taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module source_sequence_loss_tracker_top
   import sslt_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [ADDR_HALF_W-1:0] req_source_addr_high,
   input  wire logic [ADDR_HALF_W-1:0] req_source_addr_low,
   input  wire logic [SEQ_W-1:0]       req_msg_number,
   input  wire logic [PARENT_W-1:0]    req_parent_id,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [SLOT_W-1:0]           rsp_slot,
   output logic                        rsp_parent_switched,
   output logic [GAP_W-1:0]            rsp_gap_events,
   output logic [CHANGE_W-1:0]         rsp_parent_change_total,
   output logic [USED_W-1:0]           rsp_entries_used
);

   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic              addr_wr_en;
   logic              rec_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [ADDR_W-1:0] addr_wr_data;
   logic [ADDR_W-1:0] addr_rd_data;
   rec_type           rec_wr_data;
   rec_type           rec_rd_data;

   sslt_ctrl #(
      .NODES (NODES)
   ) u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_source_addr_high    (req_source_addr_high),
      .req_source_addr_low     (req_source_addr_low),
      .req_msg_number          (req_msg_number),
      .req_parent_id           (req_parent_id),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_slot                (rsp_slot),
      .rsp_parent_switched     (rsp_parent_switched),
      .rsp_gap_events          (rsp_gap_events),
      .rsp_parent_change_total (rsp_parent_change_total),
      .rsp_entries_used        (rsp_entries_used),
      .mem_rd_en               (mem_rd_en),
      .mem_rd_addr             (mem_rd_addr),
      .addr_wr_en              (addr_wr_en),
      .rec_wr_en               (rec_wr_en),
      .mem_wr_addr             (mem_wr_addr),
      .addr_wr_data            (addr_wr_data),
      .rec_wr_data             (rec_wr_data),
      .addr_rd_data            (addr_rd_data),
      .rec_rd_data             (rec_rd_data)
   );

   // source address table
   sslt_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (NODES)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (addr_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (addr_rd_data)
   );

   // per-source sequence, counters and parent
   sslt_ram #(
      .WIDTH (REC_W),
      .DEPTH (NODES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rec_rd_data)
   );

endmodule

`default_nettype wire

/* sv/sslt_checker.sv */
// ----------------------------------------------------------------------------
// sslt_checker
// port-level checks on the tracker's result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sslt_checker
   import sslt_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [SLOT_W-1:0]   rsp_slot,
   input wire logic                rsp_parent_switched,
   input wire logic [GAP_W-1:0]    rsp_gap_events,
   input wire logic [CHANGE_W-1:0] rsp_parent_change_total,
   input wire logic [USED_W-1:0]   rsp_entries_used
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_gap_events) && $stable(rsp_entries_used))
      else $error("result changed while stalled");

   // a rejected request reports nothing about any slot
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REJECTED) |-> (rsp_slot == '0)
         && !rsp_parent_switched && (rsp_gap_events == '0) && (rsp_parent_change_total == '0))
      else $error("rejected result carries slot data");

   // a fresh registration starts with clear counters
   a_new_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NEW) |-> !rsp_parent_switched
         && (rsp_gap_events == '0) && (rsp_parent_change_total == '0))
      else $error("new entry with non-zero counters");

   // a switch always leaves a non-zero change count
   a_switch_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parent_switched |-> (rsp_parent_change_total != '0)
         && (rsp_status == STATUS_UPDATED))
      else $error("parent switch without change count");

   // an accepted request takes the input out of service
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

endmodule

bind source_sequence_loss_tracker_top sslt_checker u_sslt_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_valid),
   .req_ready               (req_ready),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_status              (rsp_status),
   .rsp_slot                (rsp_slot),
   .rsp_parent_switched     (rsp_parent_switched),
   .rsp_gap_events          (rsp_gap_events),
   .rsp_parent_change_total (rsp_parent_change_total),
   .rsp_entries_used        (rsp_entries_used)
);

`default_nettype wire
